### rtl/assert_macros.svh
// shared assertion shorthands
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AST_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// condition must never hold
`define AST_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

### rtl/maid_pkg.sv
package maid_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_VERTEX_COUNT   = 3'd0;
    localparam logic [2:0] REG_TRIANGLE_COUNT = 3'd1;
    localparam logic [2:0] REG_OFFSETS_LO     = 3'd2;
    localparam logic [2:0] REG_OFFSETS_HI     = 3'd3;
    localparam logic [2:0] REG_SCALES_A       = 3'd4;
    localparam logic [2:0] REG_SCALES_B       = 3'd5;
    localparam logic [2:0] REG_SCALES_C       = 3'd6;
    localparam logic [2:0] REG_SCALES_D       = 3'd7;

    localparam int OutDataW = 104;
    localparam logic [16:0] HwMax = 17'h1FFFF;
    localparam logic [47:0] ScaledMax = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] ScaledMin = 48'h8000_0000_0000;

    // decoded item waiting for the scale multiply
    typedef struct packed {
        logic        is_index;
        logic [2:0]  channel;
        logic [17:0] item_number;
        logic [16:0] attrib_raw;
        logic [31:0] scale;
        logic [15:0] index_value;
        logic        index_error;
        logic        mesh_done;
    } dec_item_t;

endpackage

### rtl/mesh_attribute_index_decoder_top.sv
// Mesh attribute and index decoder. Each 16-bit code unit on s_tdata is one transfer; a mesh
// is CHANNELS attribute runs of vertex_count zigzag deltas followed by 3*triangle_count
// high-water-mark index codes. One code unit is taken every clock cycle unless m_tready
// stalls the pipeline (input, decode and scale multiply registers); the only loop-carried
// work is the 16-bit running sum and the counters, all updated in the decode stage. m_tuser
// is 1 on index results and m_tlast marks the final index of a mesh. Codes consumed while
// both counts are zero give no result. Configuration is written through the cfg channel
// (always ready) and should only change while the block is idle.
module mesh_attribute_index_decoder_top #(
    parameter int CHANNELS = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [15:0]                 s_tdata,   // code_unit
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // channel[2:0], item_number[20:3], attrib_raw[37:21], attrib_scaled[85:38],
    // index_value[101:86], index_error[102], zero[103]
    output logic [maid_pkg::OutDataW-1:0] m_tdata,
    output logic                        m_tuser,   // is_index
    output logic                        m_tlast,   // mesh_done
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [63:0]                 cfg_data
);
    import maid_pkg::*;

    localparam logic [2:0] LastCh = 3'(CHANNELS - 1);

    // configuration
    logic [15:0] nv_reg;
    logic [15:0] tc_reg;
    logic [63:0] off_lo_reg;
    logic [63:0] off_hi_reg;
    logic [63:0] scales_reg [4];

    // decoder state
    logic        phase_reg;
    logic [2:0]  ch_reg;
    logic [17:0] pos_reg;
    logic [15:0] rv_reg;
    logic [16:0] hw_reg;

    logic        in_v_reg;
    logic [15:0] code_reg;
    logic        p2_v_reg;
    dec_item_t   p2_reg;
    logic        m_v_reg;
    logic [OutDataW-1:0] m_data_reg;
    logic        m_user_reg;
    logic        m_last_reg;

    logic out_adv, p2_adv, in_adv, fire;

    assign out_adv  = !m_v_reg || m_tready;
    assign p2_adv   = !p2_v_reg || out_adv;
    assign in_adv   = !in_v_reg || p2_adv;
    assign fire     = in_v_reg && p2_adv;
    assign s_tready = in_adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg     <= '0;
            tc_reg     <= '0;
            off_lo_reg <= '0;
            off_hi_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                scales_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_VERTEX_COUNT:   nv_reg <= cfg_data[15:0];
                REG_TRIANGLE_COUNT: tc_reg <= cfg_data[15:0];
                REG_OFFSETS_LO:     off_lo_reg <= cfg_data;
                REG_OFFSETS_HI:     off_hi_reg <= cfg_data;
                REG_SCALES_A:       scales_reg[0] <= cfg_data;
                REG_SCALES_B:       scales_reg[1] <= cfg_data;
                REG_SCALES_C:       scales_reg[2] <= cfg_data;
                REG_SCALES_D:       scales_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode
    logic [17:0] ni;
    logic        ph_next;
    logic [2:0]  ch_next;
    logic [17:0] pos_next;
    logic [15:0] rv_next;
    logic [16:0] hw_next;
    logic        emit;
    dec_item_t   p2_next;
    logic [15:0] delta;
    logic [63:0] off_word;
    logic [15:0] off_val;
    logic [63:0] scale_word;

    assign ni    = {1'b0, tc_reg, 1'b0} + {2'b00, tc_reg};
    assign delta = {1'b0, code_reg[15:1]} ^ {16{code_reg[0]}};

    always_comb begin
        ph_next  = phase_reg;
        ch_next  = ch_reg;
        pos_next = pos_reg;
        rv_next  = rv_reg;
        hw_next  = hw_reg;
        emit     = 1'b1;
        p2_next  = '0;
        off_word = '0;
        off_val  = '0;
        scale_word = '0;

        // close a finished run or mesh before handling the code
        if (!ph_next) begin
            if (nv_reg == 16'd0) begin
                ph_next = 1'b1; ch_next = '0; pos_next = '0; rv_next = '0; hw_next = '0;
            end else if (pos_next >= {2'b00, nv_reg}) begin
                pos_next = '0;
                rv_next  = '0;
                if (ch_next == LastCh) begin
                    ph_next = 1'b1; ch_next = '0; hw_next = '0;
                end else begin
                    ch_next = ch_next + 3'd1;
                end
            end
        end
        if (ph_next && pos_next >= ni) begin
            ch_next = '0; pos_next = '0; rv_next = '0; hw_next = '0;
            if (nv_reg == 16'd0 && ni == 18'd0) begin
                ph_next = 1'b0;
                emit    = 1'b0;
            end else begin
                ph_next = (nv_reg == 16'd0);
            end
        end

        if (emit) begin
            if (!ph_next) begin
                rv_next    = rv_next + delta;
                off_word   = ch_next[2] ? off_hi_reg : off_lo_reg;
                off_val    = off_word[ch_next[1:0]*16 +: 16];
                scale_word = scales_reg[ch_next[2:1]];
                p2_next.channel     = ch_next;
                p2_next.item_number = pos_next;
                p2_next.attrib_raw  = {rv_next[15], rv_next} + {off_val[15], off_val};
                p2_next.scale       = scale_word[ch_next[0]*32 +: 32];
                pos_next = pos_next + 18'd1;
                if (pos_next >= {2'b00, nv_reg}) begin
                    pos_next = '0;
                    rv_next  = '0;
                    if (ch_next == LastCh) begin
                        ch_next = '0;
                        hw_next = '0;
                        // no index section: go straight on to the next mesh
                        ph_next = (ni != 18'd0);
                    end else begin
                        ch_next = ch_next + 3'd1;
                    end
                end
            end else begin
                p2_next.is_index    = 1'b1;
                p2_next.item_number = pos_next;
                p2_next.index_value = hw_next[15:0] - code_reg;
                p2_next.index_error = {1'b0, code_reg} > hw_next;
                if (code_reg == 16'd0 && hw_next != HwMax) begin
                    hw_next = hw_next + 17'd1;
                end
                pos_next = pos_next + 18'd1;
                if (pos_next >= ni) begin
                    p2_next.mesh_done = 1'b1;
                    ph_next = 1'b0; ch_next = '0; pos_next = '0; rv_next = '0; hw_next = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
            ch_reg    <= '0;
            pos_reg   <= '0;
            rv_reg    <= '0;
            hw_reg    <= '0;
        end else if (fire) begin
            phase_reg <= ph_next;
            ch_reg    <= ch_next;
            pos_reg   <= pos_next;
            rv_reg    <= rv_next;
            hw_reg    <= hw_next;
        end
    end

    // scale multiply and saturation
    logic signed [48:0] prod;
    logic [47:0] scaled;

    assign prod = $signed(p2_reg.attrib_raw) * $signed(p2_reg.scale);

    always_comb begin
        if (prod[48] != prod[47]) begin
            scaled = prod[48] ? ScaledMin : ScaledMax;
        end else begin
            scaled = prod[47:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            m_v_reg  <= 1'b0;
        end else begin
            if (in_adv) begin
                in_v_reg <= s_tvalid;
            end
            if (p2_adv) begin
                p2_v_reg <= in_v_reg && emit;
            end
            if (out_adv) begin
                m_v_reg <= p2_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_adv) begin
            code_reg <= s_tdata;
        end
        if (p2_adv) begin
            p2_reg <= p2_next;
        end
        if (out_adv) begin
            m_data_reg <= {1'b0, p2_reg.index_error, p2_reg.index_value, scaled,
                           p2_reg.attrib_raw, p2_reg.item_number, p2_reg.channel};
            m_user_reg <= p2_reg.is_index;
            m_last_reg <= p2_reg.mesh_done;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`include "assert_macros.svh"

    `AST_IMPLY(a_ch_in_range, aclk, aresetn, 1'b1, ch_reg <= LastCh)
    `AST_IMPLY(a_done_on_index, aclk, aresetn, m_tvalid && m_tlast, m_tuser)
    `AST_IMPLY(a_index_fields_clear, aclk, aresetn, m_tvalid && m_tuser,
               m_tdata[37:0] == {17'd0, m_tdata[20:3], 3'd0} && m_tdata[85:38] == 48'd0)
    `AST_IMPLY(a_attrib_fields_clear, aclk, aresetn, m_tvalid && !m_tuser,
               m_tdata[103:86] == 18'd0 && !m_tlast)
    `AST_NEVER(a_index_phase_rv, aclk, aresetn, phase_reg && rv_reg != 16'd0)

endmodule

### bench/mesh_attribute_index_decoder_top_test.sv
module mesh_attribute_index_decoder_top_test;
    import maid_pkg::*;

    localparam int LANES = 8;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1080;

    typedef struct packed {
        logic        is_index;
        logic [2:0]  channel;
        logic [17:0] item_number;
        logic [16:0] attrib_raw;
        logic [47:0] attrib_scaled;
        logic [15:0] index_value;
        logic        index_error;
        logic        mesh_done;
    } mesh_result_t;

    // tracks decoder state and the results still owed by the block
    class mesh_decode_tracker;
        logic [15:0]  vertex_count;
        logic [15:0]  triangle_count;
        logic [63:0]  offsets_lo;
        logic [63:0]  offsets_hi;
        logic [63:0]  scales [4];
        logic         in_index;
        logic [3:0]   chan_ctr;
        logic [17:0]  pos;
        logic [15:0]  run_sum;
        logic [16:0]  high_water;
        mesh_result_t pending_results [$];
        int           errors;
        int           results_seen;

        function new();
            vertex_count = '0;
            triangle_count = '0;
            offsets_lo = '0;
            offsets_hi = '0;
            foreach (scales[i]) scales[i] = '0;
            errors = 0;
            results_seen = 0;
            begin_mesh();
        endfunction

        function void begin_mesh();
            in_index = 1'b0;
            chan_ctr = '0;
            pos = '0;
            run_sum = '0;
            high_water = '0;
        endfunction

        function void begin_indices();
            begin_mesh();
            in_index = 1'b1;
        endfunction

        function void close_run();
            pos = '0;
            run_sum = '0;
            chan_ctr = chan_ctr + 4'd1;
            if (chan_ctr >= LANES) begin_indices();
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] data);
            case (idx)
                REG_VERTEX_COUNT:   vertex_count = data[15:0];
                REG_TRIANGLE_COUNT: triangle_count = data[15:0];
                REG_OFFSETS_LO:     offsets_lo = data;
                REG_OFFSETS_HI:     offsets_hi = data;
                REG_SCALES_A:       scales[0] = data;
                REG_SCALES_B:       scales[1] = data;
                REG_SCALES_C:       scales[2] = data;
                REG_SCALES_D:       scales[3] = data;
                default: ;
            endcase
        endfunction

        // returns 1 when the code yields a result
        function bit take_code(logic [15:0] code);
            logic [17:0]  nv;
            logic [17:0]  ni;
            logic [2:0]   ch;
            logic [15:0]  delta;
            logic [15:0]  off;
            logic [31:0]  scl;
            logic [16:0]  diff;
            int           raw;
            longint       prod;
            mesh_result_t r;
            nv = 18'(vertex_count);
            ni = 18'(3 * int'(triangle_count));
            if (!in_index) begin
                if (nv == 0 || chan_ctr >= LANES) begin_indices();
                else if (pos >= nv) close_run();
            end
            if (in_index && pos >= ni) begin
                if (nv == 0 && ni == 0) begin
                    begin_mesh();
                    return 1'b0;
                end
                if (nv != 0) begin_mesh();
                else begin_indices();
            end
            r = '0;
            if (!in_index) begin
                ch = chan_ctr[2:0];
                delta = (code >> 1) ^ {16{code[0]}};
                run_sum = run_sum + delta;
                off = (ch < 4) ? offsets_lo[ch[1:0]*16 +: 16] : offsets_hi[ch[1:0]*16 +: 16];
                scl = scales[ch[2:1]][ch[0]*32 +: 32];
                raw = int'($signed(run_sum)) + int'($signed(off));
                prod = longint'(raw) * longint'($signed(scl));
                if (prod > longint'($signed(ScaledMax))) prod = longint'($signed(ScaledMax));
                if (prod < longint'($signed(ScaledMin))) prod = longint'($signed(ScaledMin));
                r.channel = ch;
                r.item_number = pos;
                r.attrib_raw = raw[16:0];
                r.attrib_scaled = prod[47:0];
                pos = pos + 18'd1;
                if (pos >= nv) begin
                    close_run();
                    if (in_index && ni == 0) begin_mesh();
                end
            end else begin
                diff = high_water - 17'(code);
                r.is_index = 1'b1;
                r.item_number = pos;
                r.index_value = diff[15:0];
                r.index_error = (17'(code) > high_water);
                if (code == 16'h0000 && high_water < HwMax) high_water = high_water + 17'd1;
                pos = pos + 18'd1;
                if (pos >= ni) begin
                    r.mesh_done = 1'b1;
                    begin_mesh();
                end
            end
            pending_results.insert(pending_results.size(), r);
            return 1'b1;
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task compare_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("result %0d %s got %h expected %h",
                                 results_seen, name, got, want));
        endtask

        task match_result(logic [OutDataW-1:0] d, logic user, logic last);
            mesh_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %0d arrived with no decoded item pending",
                                 results_seen));
                results_seen++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("is_index", 64'(user), 64'(want.is_index));
            compare_field("channel", 64'(d[2:0]), 64'(want.channel));
            compare_field("item_number", 64'(d[20:3]), 64'(want.item_number));
            compare_field("attrib_raw", 64'(d[37:21]), 64'(want.attrib_raw));
            compare_field("attrib_scaled", 64'(d[85:38]), 64'(want.attrib_scaled));
            compare_field("index_value", 64'(d[101:86]), 64'(want.index_value));
            compare_field("index_error", 64'(d[102]), 64'(want.index_error));
            compare_field("mesh_done", 64'(last), 64'(want.mesh_done));
            compare_field("pad bit", 64'(d[103]), 64'd0);
            results_seen++;
        endtask

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [15:0]         s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [2:0]          cfg_index;
    logic [63:0]         cfg_data;

    bit no_idle = 1'b0;
    bit hold_go = 1'b0;

    mesh_decode_tracker tracker;

    mesh_attribute_index_decoder_top #(
        .CHANNELS(LANES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: random backpressure plus one long hold-off
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (hold_go && !hold_done) begin
                hold_done = 1'b1;
                hold_left = 299;
                m_tready <= 1'b0;
            end else if (no_idle) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= 26);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.match_result(m_tdata, m_tuser, m_tlast);
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("mesh_attribute_index_decoder_top regression: fail");
        $finish;
    end

    task automatic push_code(input logic [15:0] code, output bit made);
        int gap;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(99) < 26) gap++;
        end
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= code;
        do @(posedge aclk); while (!s_tready);
        made = tracker.take_code(code);
    endtask

    task automatic send_codes(input logic [15:0] codes [$]);
        bit made;
        foreach (codes[i]) push_code(codes[i], made);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // stop offering codes until the block has nothing left in flight
    task automatic wait_drain();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_counts(input int vc, input int tc);
        write_cfg(REG_VERTEX_COUNT, {16'($urandom), 32'($urandom), 16'(vc)});
        write_cfg(REG_TRIANGLE_COUNT, {16'($urandom), 32'($urandom), 16'(tc)});
    endtask

    function automatic logic [15:0] offset_lane();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] scale_lane();
        case ($urandom_range(6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'h0100_0000;
            4: return 32'($urandom_range(32'h0400_0000)) - 32'h0200_0000;
            default: return 32'($urandom);
        endcase
    endfunction

    // mostly well-formed index codes (at or below the high water mark), some noise
    function automatic logic [15:0] next_code();
        int sel;
        int top;
        sel = $urandom_range(99);
        top = (tracker.high_water > 17'd65535) ? 65535 : int'(tracker.high_water);
        if (sel < 30) return 16'h0000;
        if (sel < 60) return 16'($urandom_range(top));
        if (sel < 90) return 16'($urandom);
        case ($urandom_range(3))
            0: return 16'hFFFF;
            1: return 16'h8000;
            2: return 16'h7FFF;
            default: return 16'h0001;
        endcase
    endfunction

    initial begin
        int vc;
        int tc;
        int len;
        int n;
        int phase;
        int rand_made;
        bit made;
        tracker = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // both counts zero after reset: code is swallowed
        send_codes('{16'hFFFF});
        wait_drain();

        // one vertex per channel, extreme offsets and scales, zero scale on channel 2
        write_counts(1, 1);
        write_cfg(REG_OFFSETS_LO, 64'h8000_7FFF_0001_0000);
        write_cfg(REG_OFFSETS_HI, 64'h8000_8000_7FFF_7FFF);
        write_cfg(REG_SCALES_A, 64'h8000_0000_7FFF_FFFF);
        write_cfg(REG_SCALES_B, 64'h7FFF_FFFF_0000_0000);
        write_cfg(REG_SCALES_C, 64'h8000_0000_0100_0000);
        write_cfg(REG_SCALES_D, 64'h7FFF_FFFF_8000_0000);
        send_codes('{16'hFFFF, 16'hFFFE, 16'h0001, 16'hFFFF, 16'hFFFE, 16'h8000,
                     16'hFFFF, 16'hFFFE, 16'h0000, 16'h0000, 16'hFFFF});
        wait_drain();

        // no vertices: mesh is indices only, last code out of range
        write_counts(0, 2);
        send_codes('{16'h0000, 16'h0001, 16'h0000, 16'h0002, 16'h0000, 16'h0004});
        wait_drain();

        // no triangles: attribute runs back to back
        write_counts(1, 0);
        send_codes('{16'h0002, 16'h8001, 16'h7FFF, 16'h0003, 16'h5555, 16'hAAAA,
                     16'h0000, 16'hFFFF});
        wait_drain();

        // long index list with no idle cycles: high water mark climbs on zero codes
        no_idle = 1'b1;
        write_counts(0, 65535);
        for (int i = 0; i < 240; i++) begin
            push_code((i < 150) ? 16'h0000 : next_code(), made);
        end
        no_idle = 1'b0;
        wait_drain();

        // largest vertex count, then lowered while inside the first run
        write_counts(65535, 1);
        repeat (4) push_code(next_code(), made);
        wait_drain();
        write_counts(2, 1);
        repeat (17) push_code(next_code(), made);

        rand_made = 0;
        phase = 0;
        while (rand_made < RANDOM_ITEMS) begin
            wait_drain();
            n = $urandom_range(99);
            vc = (n < 8) ? 0 : (n < 80) ? $urandom_range(4, 1) : $urandom_range(12, 5);
            n = $urandom_range(99);
            tc = (n < 8) ? 0 : (n < 80) ? $urandom_range(4, 1) : $urandom_range(10, 5);
            if (phase == 3 && vc == 0) vc = 2;
            write_counts(vc, tc);
            if ($urandom_range(1)) write_cfg(REG_OFFSETS_LO,
                {offset_lane(), offset_lane(), offset_lane(), offset_lane()});
            if ($urandom_range(1)) write_cfg(REG_OFFSETS_HI,
                {offset_lane(), offset_lane(), offset_lane(), offset_lane()});
            if ($urandom_range(1)) write_cfg(REG_SCALES_A, {scale_lane(), scale_lane()});
            if ($urandom_range(1)) write_cfg(REG_SCALES_B, {scale_lane(), scale_lane()});
            if ($urandom_range(1)) write_cfg(REG_SCALES_C, {scale_lane(), scale_lane()});
            if ($urandom_range(1)) write_cfg(REG_SCALES_D, {scale_lane(), scale_lane()});
            len = LANES * vc + 3 * tc;
            if (len == 0) begin
                n = 4;
            end else begin
                case ($urandom_range(3))
                    0: n = $urandom_range(len, 1);
                    1: n = $urandom_range(3 * len, len);
                    default: n = len;
                endcase
            end
            // receiver stalls for a long stretch while codes keep coming
            if (phase == 3) begin
                hold_go = 1'b1;
                if (n < 80) n = 80;
            end
            repeat (n) begin
                push_code(next_code(), made);
                rand_made += made;
            end
            phase++;
        end

        wait_drain();
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("mesh_attribute_index_decoder_top regression: pass");
        else
            $display("mesh_attribute_index_decoder_top regression: fail");
        $finish;
    end

endmodule
